>>> src/bli2d_pkg.sv
package bli2d_pkg;

    localparam int MAX_X_POINTS = 32;
    localparam int MAX_Y_POINTS = 32;
    localparam int GRID_DEPTH = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int XA_W = $clog2(MAX_X_POINTS);
    localparam int YA_W = $clog2(MAX_Y_POINTS);
    localparam int GA_W = $clog2(GRID_DEPTH);
    localparam int CNT_W = 6;
    localparam int VAL_W = 32;
    localparam int TW = VAL_W + 1;
    localparam int LW = 104;
    localparam int MUL_STEPS = TW;
    localparam int STEP_W = $clog2(LW);

    typedef enum logic [1:0] {
        CMD_WR_X = 2'd0,
        CMD_WR_Y = 2'd1,
        CMD_WR_GRID = 2'd2,
        CMD_EVAL = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        SOP_NONE,
        SOP_INIT,
        SOP_CMP1,
        SOP_CMPN,
        SOP_RDK,
        SOP_CMPK
    } t_sop;

    typedef enum logic [1:0] {
        LSEL_ROW0,
        LSEL_ROW1,
        LSEL_COL
    } t_lsel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SINIT,
        ST_SCMP1,
        ST_SCMPN,
        ST_SLOOP,
        ST_SCMPK,
        ST_FETCH,
        ST_L0,
        ST_W0,
        ST_L1,
        ST_W1,
        ST_L2,
        ST_W2,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        LS_IDLE,
        LS_MUL,
        LS_DIV,
        LS_FIN
    } t_lstate;

    typedef struct packed {
        logic [1:0] cmd;
        logic [9:0] index;
        logic signed [31:0] write_value;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result;
        logic saturated;
        logic bad_interval;
    } t_out;

    typedef struct packed {
        logic accept;
        logic sel_y;
        t_sop sop;
        logic fetch;
        logic [2:0] fcnt;
        logic lerp_start;
        t_lsel lerp_sel;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic srch_more;
        logic lerp_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> src/bli2d_ram.sv
module bli2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bli2d_lerp.sv
module bli2d_lerp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [bli2d_pkg::LW-1:0] i_low,
    input  logic signed [bli2d_pkg::LW-1:0] i_high,
    input  logic signed [bli2d_pkg::TW-1:0] i_t,
    input  logic signed [bli2d_pkg::TW-1:0] i_span,
    output logic                            o_done,
    output logic signed [bli2d_pkg::LW-1:0] o_res,
    output logic                            o_bad
);
    import bli2d_pkg::*;

    t_lstate r_state;
    logic signed [LW-1:0] r_low;
    logic [LW-1:0] r_ma;
    logic [LW-1:0] r_acc;
    logic [TW-1:0] r_mb;
    logic [TW-1:0] r_md;
    logic [TW-1:0] r_rem;
    logic [STEP_W-1:0] r_cnt;
    logic r_neg;
    logic r_bad;

    logic signed [LW-1:0] diff;
    logic [TW:0] rem2;
    logic ge;

    assign diff = i_high - i_low;
    assign rem2 = {r_rem, r_acc[LW-1]};
    assign ge = rem2 >= {1'b0, r_md};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
        end else begin
            case (r_state)
                LS_IDLE: begin
                    if (i_start) begin
                        r_low <= i_low;
                        r_ma <= diff[LW-1] ? LW'(-diff) : LW'(diff);
                        r_mb <= i_t[TW-1] ? TW'(-i_t) : TW'(i_t);
                        r_md <= i_span[TW-1] ? TW'(-i_span) : TW'(i_span);
                        r_neg <= diff[LW-1] ^ i_t[TW-1] ^ i_span[TW-1];
                        r_acc <= '0;
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_bad <= (i_span == '0);
                        r_state <= (i_span == '0) ? LS_FIN : LS_MUL;
                    end
                end
                LS_MUL: begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_ma;
                    end
                    r_ma <= {r_ma[LW-2:0], 1'b0};
                    r_mb <= {1'b0, r_mb[TW-1:1]};
                    if (r_cnt == STEP_W'(MUL_STEPS - 1)) begin
                        r_cnt <= '0;
                        r_state <= LS_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                LS_DIV: begin
                    r_rem <= ge ? TW'(rem2 - {1'b0, r_md}) : rem2[TW-1:0];
                    r_acc <= {r_acc[LW-2:0], ge};
                    if (r_cnt == STEP_W'(LW - 1)) begin
                        r_state <= LS_FIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                LS_FIN: begin
                    r_state <= LS_IDLE;
                end
                default: begin
                    r_state <= LS_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == LS_FIN);
    assign o_res = r_low + (r_neg ? $signed(-r_acc) : $signed(r_acc));
    assign o_bad = r_bad;

endmodule

>>> src/bli2d_ctrl.sv
module bli2d_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_in_cmd,
    output logic                o_in_ready,
    output bli2d_pkg::t_dp_cmd  o_cmd,
    input  bli2d_pkg::t_dp_stat i_stat
);
    import bli2d_pkg::*;

    t_state r_state, n_state;
    logic r_sel_y, n_sel_y;
    logic [2:0] r_fcnt, n_fcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel_y <= 1'b0;
            r_fcnt <= '0;
        end else begin
            r_state <= n_state;
            r_sel_y <= n_sel_y;
            r_fcnt <= n_fcnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel_y = r_sel_y;
        n_fcnt = r_fcnt;
        o_in_ready = 1'b0;
        o_cmd = '0;
        o_cmd.sop = SOP_NONE;
        o_cmd.lerp_sel = LSEL_ROW0;
        o_cmd.sel_y = r_sel_y;
        o_cmd.fcnt = r_fcnt;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_in_cmd == CMD_EVAL) begin
                    n_sel_y = 1'b0;
                    n_state = ST_SINIT;
                end
            end
            ST_SINIT: begin
                o_cmd.sop = SOP_INIT;
                n_state = ST_SCMP1;
            end
            ST_SCMP1: begin
                o_cmd.sop = SOP_CMP1;
                n_state = ST_SCMPN;
            end
            ST_SCMPN: begin
                o_cmd.sop = SOP_CMPN;
                n_state = ST_SLOOP;
            end
            ST_SLOOP: begin
                o_cmd.sop = SOP_RDK;
                if (i_stat.srch_more) begin
                    n_state = ST_SCMPK;
                end else if (!r_sel_y) begin
                    n_sel_y = 1'b1;
                    n_state = ST_SINIT;
                end else begin
                    n_fcnt = '0;
                    n_state = ST_FETCH;
                end
            end
            ST_SCMPK: begin
                o_cmd.sop = SOP_CMPK;
                n_state = ST_SLOOP;
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                if (r_fcnt == 3'd4) begin
                    n_state = ST_L0;
                end else begin
                    n_fcnt = r_fcnt + 1'b1;
                end
            end
            ST_L0: begin
                o_cmd.lerp_start = 1'b1;
                n_state = ST_W0;
            end
            ST_W0: begin
                if (i_stat.lerp_done) begin
                    n_state = ST_L1;
                end
            end
            ST_L1: begin
                o_cmd.lerp_sel = LSEL_ROW1;
                o_cmd.lerp_start = 1'b1;
                n_state = ST_W1;
            end
            ST_W1: begin
                o_cmd.lerp_sel = LSEL_ROW1;
                if (i_stat.lerp_done) begin
                    n_state = ST_L2;
                end
            end
            ST_L2: begin
                o_cmd.lerp_sel = LSEL_COL;
                o_cmd.lerp_start = 1'b1;
                n_state = ST_W2;
            end
            ST_W2: begin
                o_cmd.lerp_sel = LSEL_COL;
                if (i_stat.lerp_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_eval_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid && i_in_cmd == CMD_EVAL) |=> r_state == ST_SINIT)
        else $error("evaluate transaction did not start the search");

    a_write_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid && i_in_cmd != CMD_EVAL) |=> r_state == ST_IDLE)
        else $error("write transaction left the idle state");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded over a pending transaction");

    a_col_done_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_W2 && i_stat.lerp_done) |=> r_state == ST_OUT)
        else $error("final interpolation did not lead to output");

endmodule

>>> src/bli2d_dp.sv
module bli2d_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [5:0]               i_cfg_wdata,
    input  bli2d_pkg::t_in           i_in,
    input  bli2d_pkg::t_dp_cmd       i_cmd,
    output bli2d_pkg::t_dp_stat      o_stat,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output bli2d_pkg::t_out          o_out
);
    import bli2d_pkg::*;

    localparam logic signed [LW-1:0] SAT_MAX = LW'(32'h7FFF_FFFF);
    localparam logic signed [LW-1:0] SAT_MIN = {{(LW-VAL_W){1'b1}}, 32'h8000_0000};

    logic [CNT_W-1:0] r_x_count, r_y_count;
    logic [CNT_W-1:0] nx, ny, n_sel;
    logic signed [VAL_W-1:0] r_qx, r_qy, q_sel, d_sel;
    logic [XA_W-1:0] r_hi, r_lo, r_k, k_next, srch_addr, r_i, r_j;
    logic [XA_W-1:0] x_raddr, y_raddr;
    logic [GA_W-1:0] g_raddr, r0, r1;
    logic [VAL_W-1:0] x_rdata, y_rdata, g_rdata;
    logic signed [VAL_W-1:0] r_x0, r_x1, r_y0, r_y1, r_g00, r_g01, r_g10, r_g11;
    logic signed [LW-1:0] r_o0, r_o1, r_res;
    logic signed [LW-1:0] l_low, l_high, l_res;
    logic signed [TW-1:0] l_t, l_span;
    logic l_done, l_bad, r_bad;
    logic r_out_valid;
    t_out r_out;
    logic we_x, we_y, we_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_count <= CNT_W'(2);
            r_y_count <= CNT_W'(2);
        end else if (i_cfg_we) begin
            if (i_cfg_index) begin
                r_y_count <= i_cfg_wdata;
            end else begin
                r_x_count <= i_cfg_wdata;
            end
        end
    end

    assign nx = (r_x_count < CNT_W'(2)) ? CNT_W'(2) :
                (r_x_count > CNT_W'(MAX_X_POINTS)) ? CNT_W'(MAX_X_POINTS) : r_x_count;
    assign ny = (r_y_count < CNT_W'(2)) ? CNT_W'(2) :
                (r_y_count > CNT_W'(MAX_Y_POINTS)) ? CNT_W'(MAX_Y_POINTS) : r_y_count;

    assign we_x = i_cmd.accept && i_in.cmd == CMD_WR_X && i_in.index < 10'(MAX_X_POINTS);
    assign we_y = i_cmd.accept && i_in.cmd == CMD_WR_Y && i_in.index < 10'(MAX_Y_POINTS);
    assign we_g = i_cmd.accept && i_in.cmd == CMD_WR_GRID && i_in.index < 11'(GRID_DEPTH);

    assign n_sel = i_cmd.sel_y ? ny : nx;
    assign q_sel = i_cmd.sel_y ? r_qy : r_qx;
    assign d_sel = i_cmd.sel_y ? $signed(y_rdata) : $signed(x_rdata);
    assign k_next = XA_W'(({1'b0, r_hi} + {1'b0, r_lo}) >> 1);
    assign o_stat.srch_more = {1'b0, r_hi} > ({1'b0, r_lo} + 1'b1);

    always_comb begin
        case (i_cmd.sop)
            SOP_INIT: srch_addr = XA_W'(1);
            SOP_CMP1: srch_addr = XA_W'(n_sel - 1'b1);
            default:  srch_addr = k_next;
        endcase
    end

    assign r0 = GA_W'(r_j - 1'b1) * GA_W'(nx);
    assign r1 = GA_W'(r_j) * GA_W'(nx);

    always_comb begin
        x_raddr = srch_addr;
        y_raddr = srch_addr;
        case (i_cmd.fcnt[1:0])
            2'd0: g_raddr = r0 + GA_W'(r_i) - 1'b1;
            2'd1: g_raddr = r0 + GA_W'(r_i);
            2'd2: g_raddr = r1 + GA_W'(r_i) - 1'b1;
            default: g_raddr = r1 + GA_W'(r_i);
        endcase
        if (i_cmd.fetch) begin
            x_raddr = (i_cmd.fcnt == 3'd0) ? r_i - 1'b1 : r_i;
            y_raddr = (i_cmd.fcnt == 3'd0) ? r_j - 1'b1 : r_j;
        end
    end

    bli2d_ram #(.WIDTH(VAL_W), .DEPTH(MAX_X_POINTS)) u_x_ram (
        .i_clk(i_clk), .i_we(we_x), .i_waddr(i_in.index[XA_W-1:0]),
        .i_wdata(i_in.write_value), .i_raddr(x_raddr), .o_rdata(x_rdata)
    );

    bli2d_ram #(.WIDTH(VAL_W), .DEPTH(MAX_Y_POINTS)) u_y_ram (
        .i_clk(i_clk), .i_we(we_y), .i_waddr(i_in.index[YA_W-1:0]),
        .i_wdata(i_in.write_value), .i_raddr(y_raddr), .o_rdata(y_rdata)
    );

    bli2d_ram #(.WIDTH(VAL_W), .DEPTH(GRID_DEPTH)) u_grid_ram (
        .i_clk(i_clk), .i_we(we_g), .i_waddr(i_in.index[GA_W-1:0]),
        .i_wdata(i_in.write_value), .i_raddr(g_raddr), .o_rdata(g_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_qx <= i_in.query_x;
            r_qy <= i_in.query_y;
        end
        case (i_cmd.sop)
            SOP_INIT: begin
                r_hi <= XA_W'(n_sel - 1'b1);
                r_lo <= XA_W'(1);
            end
            SOP_CMP1: begin
                if (q_sel <= d_sel) begin
                    r_hi <= XA_W'(1);
                end
            end
            SOP_CMPN: begin
                if (q_sel >= d_sel) begin
                    r_lo <= XA_W'(n_sel - 1'b1);
                end
            end
            SOP_RDK: begin
                r_k <= k_next;
                if (!o_stat.srch_more) begin
                    if (i_cmd.sel_y) begin
                        r_j <= r_hi;
                    end else begin
                        r_i <= r_hi;
                    end
                end
            end
            SOP_CMPK: begin
                if (q_sel <= d_sel) begin
                    r_hi <= r_k;
                end
                if (q_sel >= d_sel) begin
                    r_lo <= r_k;
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.fetch) begin
            case (i_cmd.fcnt)
                3'd1: begin
                    r_g00 <= g_rdata;
                    r_x0 <= x_rdata;
                    r_y0 <= y_rdata;
                end
                3'd2: begin
                    r_g01 <= g_rdata;
                    r_x1 <= x_rdata;
                    r_y1 <= y_rdata;
                end
                3'd3: r_g10 <= g_rdata;
                3'd4: r_g11 <= g_rdata;
                default: begin
                end
            endcase
        end
        if (l_done) begin
            case (i_cmd.lerp_sel)
                LSEL_ROW0: r_o0 <= l_res;
                LSEL_ROW1: r_o1 <= l_res;
                default:   r_res <= l_res;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad <= 1'b0;
        end else if (i_cmd.accept) begin
            r_bad <= 1'b0;
        end else if (l_done && l_bad) begin
            r_bad <= 1'b1;
        end
    end

    always_comb begin
        case (i_cmd.lerp_sel)
            LSEL_ROW0: begin
                l_low = LW'(r_g00);
                l_high = LW'(r_g01);
            end
            LSEL_ROW1: begin
                l_low = LW'(r_g10);
                l_high = LW'(r_g11);
            end
            default: begin
                l_low = r_o0;
                l_high = r_o1;
            end
        endcase
        if (i_cmd.lerp_sel == LSEL_COL) begin
            l_t = TW'(r_qy) - TW'(r_y0);
            l_span = TW'(r_y1) - TW'(r_y0);
        end else begin
            l_t = TW'(r_qx) - TW'(r_x0);
            l_span = TW'(r_x1) - TW'(r_x0);
        end
    end

    bli2d_lerp u_lerp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.lerp_start),
        .i_low(l_low), .i_high(l_high), .i_t(l_t), .i_span(l_span),
        .o_done(l_done), .o_res(l_res), .o_bad(l_bad)
    );

    assign o_stat.lerp_done = l_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.bad_interval <= r_bad;
            if (r_res > SAT_MAX) begin
                r_out.result <= 32'sh7FFF_FFFF;
                r_out.saturated <= 1'b1;
            end else if (r_res < SAT_MIN) begin
                r_out.result <= 32'sh8000_0000;
                r_out.saturated <= 1'b1;
            end else begin
                r_out.result <= r_res[VAL_W-1:0];
                r_out.saturated <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

endmodule

>>> src/bilinear_lookup_table_2d_core.sv
// Two-dimensional lookup table with bilinear interpolation in signed Q16.16.
// The input channel (i_in_valid, o_in_ready, i_in) carries one command per
// transaction: write an x breakpoint, a y breakpoint or a grid entry, or evaluate
// a query point. Writes complete in the cycle they are accepted and give no result.
// An evaluate gives exactly one transaction on the output channel (o_out_valid,
// i_out_ready, o_out) with the result, a saturation flag and a bad interval flag.
// The configuration port sets the x and y breakpoint counts and is to be written
// only while the block is idle; the block itself does not enforce this.
// One evaluate is processed at a time. It runs two binary searches over the axis
// memories, an operand fetch, three interpolations in a shared unit whose serial
// multiplier and restoring divider run one after the other, and a load of the
// result; an interval of zero width skips the multiplier and divider.
// A new command is accepted once the previous result sits in the output register.
// When the receiver stalls, the result holds in that register, and a following
// evaluate waits at its end until the register frees.
// Reset clears the control state and sets both counts to two; the table memories
// keep no reset value and must be written before use.
module bilinear_lookup_table_2d_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [5:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bli2d_pkg::t_in     i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bli2d_pkg::t_out    o_out
);
    import bli2d_pkg::*;

    t_dp_cmd cmd;
    t_dp_stat stat;

    bli2d_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_in_cmd(i_in.cmd), .o_in_ready(o_in_ready), .o_cmd(cmd), .i_stat(stat)
    );

    bli2d_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata), .i_in(i_in),
        .i_cmd(cmd), .o_stat(stat), .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready), .o_out(o_out)
    );

endmodule
